### rtl/chm_pkg.sv
package chm_pkg;

  // Fixed field widths of the access and result beats.
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CYC_W      = 7;
  localparam int unsigned OFF_W      = 4;
  localparam int unsigned IDXB_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // An index_bits value of up to 15 leaves at most 15 raw index bits.
  localparam int unsigned IDX_RAW_W = 15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd2;

  // Cache modes.
  localparam logic MODE_DIRECT  = 1'b0;
  localparam logic MODE_TWO_WAY = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [OFF_W-1:0]  OFFSET_BITS_RST = 4'd4;
  localparam logic [IDXB_W-1:0] INDEX_BITS_RST  = 4'd6;

  // Cycle charges.
  localparam logic [CYC_W-1:0] MISS_PENALTY = 7'd100;
  localparam logic [CYC_W-1:0] ONE_PROBE    = 7'd1;
  localparam logic [CYC_W-1:0] TWO_PROBES   = 7'd2;

endpackage

### rtl/chm_index_unit.sv
module chm_index_unit #(
  parameter int unsigned LINES      = 1024,
  parameter int unsigned ADDR_WIDTH = 32,
  localparam int unsigned LINE_AW   = (LINES > 1) ? $clog2(LINES) : 1,
  localparam int unsigned TAG_W     = (ADDR_WIDTH >= 32) ? 32 : ADDR_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [chm_pkg::ADDR_W-1:0]    address_i,
  input  logic [chm_pkg::OFF_W-1:0]     offset_bits_i,
  input  logic [chm_pkg::IDXB_W-1:0]    index_bits_i,
  output logic                          vld_o,
  output logic [LINE_AW-1:0]            idx_o,
  output logic [TAG_W-1:0]              tag_o
);
  import chm_pkg::*;

  // Reduction modulo LINES by a reciprocal multiply. With a 15-bit raw
  // index and at most 2^16 lines, the 33-bit reciprocal gives the exact
  // quotient, so no correction step is needed.
  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? '1 :
                                            ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / LINES + 64'd1);

  logic [ADDR_W-1:0]    addr_m;
  logic [IDXB_W:0]      shift_amt;
  logic [IDX_RAW_W-1:0] idx_mask;
  logic [IDX_RAW_W-1:0] raw_d;
  logic [TAG_W-1:0]     tag_d;

  logic                 v0_q, v1_q;
  logic [IDX_RAW_W-1:0] raw0_q, raw1_q;
  logic [TAG_W-1:0]     tag0_q, tag1_q;
  logic [15:0]          quot_q;

  logic [47:0]          prod_quot;
  logic [32:0]          prod_back;
  logic [32:0]          rem;

  always_comb begin
    addr_m    = address_i & ADDR_MASK;
    shift_amt = {1'b0, offset_bits_i} + {1'b0, index_bits_i};
    idx_mask  = ~({IDX_RAW_W{1'b1}} << index_bits_i);
    raw_d     = IDX_RAW_W'(addr_m >> offset_bits_i) & idx_mask;
    tag_d     = TAG_W'(addr_m >> shift_amt);
  end

  assign prod_quot = 48'(raw0_q) * 48'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= start_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      raw0_q <= raw_d;
      tag0_q <= tag_d;
    end
    if (v0_q) begin
      raw1_q <= raw0_q;
      tag1_q <= tag0_q;
      quot_q <= prod_quot[47:32];
    end
  end

  assign prod_back = 33'(quot_q) * 33'(LINES);
  assign rem       = 33'(raw1_q) - prod_back;

  assign vld_o = v1_q;
  assign idx_o = rem[LINE_AW-1:0];
  assign tag_o = tag1_q;

endmodule

### rtl/chm_line_ram.sv
module chm_line_ram #(
  parameter int unsigned LINES   = 1024,
  parameter int unsigned ENT_W   = 67,
  localparam int unsigned LINE_AW = (LINES > 1) ? $clog2(LINES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [LINE_AW-1:0] rd_addr_i,
  output logic [ENT_W-1:0]   rd_data_o,
  input  logic               wr_en_i,
  input  logic [LINE_AW-1:0] wr_addr_i,
  input  logic [ENT_W-1:0]   wr_data_i,
  output logic               clr_busy_o
);

  localparam logic [LINE_AW-1:0] LAST_LINE = LINE_AW'(LINES - 1);

  logic [ENT_W-1:0]   mem_q [LINES];
  logic [ENT_W-1:0]   rd_data_q;
  logic [LINE_AW-1:0] clr_cnt_q;
  logic               clr_busy_q;

  // After reset every line is swept once and cleared whole to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == LAST_LINE) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + LINE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

### rtl/cache_hit_miss_model_core.sv
// Tag-only cache hit/miss model, direct-mapped or two-way with replacement
// of the way not most recently filled.
//
// Access channel: in_valid_i/in_ready_o move one beat carrying a byte
// address. Result channel: out_valid_o/out_ready_i move one beat with the
// hit flag, the cycles charged to this access and the running miss, access
// and cycle totals, all 32-bit and wrapping.
// Configuration channel: cfg_valid_i/cfg_ready_o move one beat with a
// register index (0 mode, 1 offset bits, 2 index bits) and data; always
// ready. Write it only while no access is in flight; this is not enforced.
//
// Each access runs through its steps in order, none overlapped with the
// next access: address split, multiply-based reduction of the index to the
// line count, line memory read, and read-modify-write into the result
// register.
//
// After reset a clearing pass empties the line memory; in_ready_o stays
// low until it is done. If the receiver stalls, the result is held and a
// new access may still be taken, but it waits in the lookup step until the
// previous result beat has gone.
module cache_hit_miss_model_core #(
  parameter int unsigned LINES      = 1024,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [chm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [chm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [chm_pkg::ADDR_W-1:0]       address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [chm_pkg::CYC_W-1:0]        access_cycles_o,
  output logic [chm_pkg::CNT_W-1:0]        miss_total_o,
  output logic [chm_pkg::CNT_W-1:0]        access_total_o,
  output logic [chm_pkg::CNT_W-1:0]        cycle_total_o
);
  import chm_pkg::*;

  localparam int unsigned LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned TAG_W   = (ADDR_WIDTH >= 32) ? 32 : ADDR_WIDTH;
  // A line holds {recent, valid1, tag1, valid0, tag0}.
  localparam int unsigned ENT_W   = 2 * TAG_W + 3;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SPLIT  = 4'b0100,
    ST_LOOKUP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic              cache_mode_q;
  logic [OFF_W-1:0]  offset_bits_q;
  logic [IDXB_W-1:0] index_bits_q;

  // Access in flight.
  logic [LINE_AW-1:0] idx_q;
  logic [TAG_W-1:0]   tag_q;

  // Result register; the totals are read straight from the counters.
  logic              out_valid_q, out_valid_d;
  logic              hit_q;
  logic [CYC_W-1:0]  cyc_q;
  logic [CNT_W-1:0]  miss_cnt_q, access_cnt_q, cycle_cnt_q;

  logic               in_accept;
  logic               split_vld;
  logic [LINE_AW-1:0] split_idx;
  logic [TAG_W-1:0]   split_tag;

  logic               rd_en;
  logic [ENT_W-1:0]   rd_data;
  logic               wr_en;
  logic [ENT_W-1:0]   wr_data;
  logic               clr_busy;

  // Fields of the line read back and the updated line.
  logic [TAG_W-1:0] tag0, tag1, tag0_n, tag1_n;
  logic             vld0, vld1, vld0_n, vld1_n, rec, rec_n;
  logic             hit_c;
  logic [CYC_W-1:0] cyc_c;
  logic             finish;

  chm_index_unit #(
    .LINES      (LINES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_index (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_accept),
    .address_i     (address_i),
    .offset_bits_i (offset_bits_q),
    .index_bits_i  (index_bits_q),
    .vld_o         (split_vld),
    .idx_o         (split_idx),
    .tag_o         (split_tag)
  );

  chm_line_ram #(
    .LINES (LINES),
    .ENT_W (ENT_W)
  ) u_lines (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (split_idx),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (idx_q),
    .wr_data_i  (wr_data),
    .clr_busy_o (clr_busy)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_mode_q  <= MODE_DIRECT;
      offset_bits_q <= OFFSET_BITS_RST;
      index_bits_q  <= INDEX_BITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CACHE_MODE:  cache_mode_q  <= cfg_data_i[0];
        REG_OFFSET_BITS: offset_bits_q <= cfg_data_i[OFF_W-1:0];
        REG_INDEX_BITS:  index_bits_q  <= cfg_data_i[IDXB_W-1:0];
        default: ;
      endcase
    end
  end

  // The lookup step completes only when the result register is free.
  assign finish = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready_i);
  assign rd_en  = (state_q == ST_SPLIT) && split_vld;
  assign wr_en  = finish;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (!clr_busy) state_d = ST_IDLE;
      ST_IDLE:   if (in_accept) state_d = ST_SPLIT;
      ST_SPLIT:  if (split_vld) state_d = ST_LOOKUP;
      ST_LOOKUP: if (finish) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Hit check and replacement on the line read back.
  always_comb begin
    tag0 = rd_data[TAG_W-1:0];
    vld0 = rd_data[TAG_W];
    tag1 = rd_data[2*TAG_W:TAG_W+1];
    vld1 = rd_data[2*TAG_W+1];
    rec  = rd_data[2*TAG_W+2];

    tag0_n = tag0;
    vld0_n = vld0;
    tag1_n = tag1;
    vld1_n = vld1;
    rec_n  = rec;
    hit_c  = 1'b0;
    cyc_c  = ONE_PROBE;

    if (vld0 && (tag0 == tag_q)) begin
      hit_c = 1'b1;
    end else if ((cache_mode_q == MODE_DIRECT) || !vld0) begin
      vld0_n = 1'b1;
      tag0_n = tag_q;
      rec_n  = 1'b0;
    end else begin
      // Second probe of way 1.
      cyc_c = TWO_PROBES;
      if (vld1 && (tag1 == tag_q)) begin
        hit_c = 1'b1;
      end else if (!vld1 || !rec) begin
        vld1_n = 1'b1;
        tag1_n = tag_q;
        rec_n  = 1'b1;
      end else begin
        tag0_n = tag_q;
        rec_n  = 1'b0;
      end
    end

    if (!hit_c) begin
      cyc_c = cyc_c + MISS_PENALTY;
    end

    wr_data = {rec_n, vld1_n, tag1_n, vld0_n, tag0_n};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      out_valid_q  <= 1'b0;
      miss_cnt_q   <= '0;
      access_cnt_q <= '0;
      cycle_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (finish) begin
        miss_cnt_q   <= miss_cnt_q + CNT_W'(!hit_c);
        access_cnt_q <= access_cnt_q + CNT_W'(1);
        cycle_cnt_q  <= cycle_cnt_q + CNT_W'(cyc_c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      idx_q <= split_idx;
      tag_q <= split_tag;
    end
    if (finish) begin
      hit_q <= hit_c;
      cyc_q <= cyc_c;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign access_cycles_o = cyc_q;
  assign miss_total_o    = miss_cnt_q;
  assign access_total_o  = access_cnt_q;
  assign cycle_total_o   = cycle_cnt_q;

endmodule

### sim/tb_cache_hit_miss_model_core.sv
`timescale 1ns / 100ps

module tb_cache_hit_miss_model_core;
  import chm_pkg::*;

  // The block is built with its default geometry; the testbench keeps its own
  // copy of the line count so that its tag arrays match the block's.
  localparam int unsigned LINES = 1024;

  // A register index that has no register behind it; a write to it is dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned PRESSURE_PHASE  = 4;
  localparam int unsigned LONG_HOLD       = 300;
  localparam int unsigned MAX_GAP         = 40;
  localparam int unsigned TAIL_CYCLES     = 16;
  // The limit covers the clearing pass, every access, the sender's gaps and
  // the receiver's stalls; it is many times the slowest correct run.
  localparam int unsigned CYCLE_LIMIT     = 400000;

  // Expected content of one result beat.
  typedef struct packed {
    logic             hit;
    logic [CYC_W-1:0] cycles;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] accesses;
    logic [CNT_W-1:0] cycle_sum;
  } lookup_result_t;

  typedef enum logic {ROW_ACCESS, ROW_WRITE} row_kind_e;

  // One row of the directed table: either an access beat or a register write.
  // Rows with typed set carry a result that is obvious from the cache state;
  // all other rows are checked against the predictor.
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [ADDR_W-1:0]    value;
    logic                 typed;
    lookup_result_t       want;
  } stim_row_t;

  // Cache geometry used by one random phase.
  typedef struct packed {
    logic              mode;
    logic [OFF_W-1:0]  offset_bits;
    logic [IDXB_W-1:0] index_bits;
  } geometry_t;

  localparam lookup_result_t NO_WANT = '0;
  localparam int unsigned NUM_ROWS = 30;

  // The directed part starts right after reset with the reset geometry:
  // direct-mapped, 16-byte blocks, 64 lines, so the tag starts at bit 10.
  // The first six rows fill, hit, conflict and evict at line 0 and line 63.
  // Then two-way mode walks the fill order: an empty second way, hits in
  // both ways, replacement of the way not most recently filled, and an
  // empty first way at a fresh line. Back in direct mode a line held by the
  // first way is overwritten. The register extremes follow: no index bits
  // at all (one line), the widest out-of-range shift, and a write to an
  // index with no register.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_ACCESS, '0, 32'h0000_0000, 1'b1, '{1'b0, 7'd101, 32'd1, 32'd1, 32'd101}},
    '{ROW_ACCESS, '0, 32'h0000_0000, 1'b1, '{1'b1, 7'd1,   32'd1, 32'd2, 32'd102}},
    '{ROW_ACCESS, '0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 7'd101, 32'd2, 32'd3, 32'd203}},
    '{ROW_ACCESS, '0, 32'hFFFF_FFF0, 1'b1, '{1'b1, 7'd1,   32'd2, 32'd4, 32'd204}},
    '{ROW_ACCESS, '0, 32'h0000_0400, 1'b1, '{1'b0, 7'd101, 32'd3, 32'd5, 32'd305}},
    '{ROW_ACCESS, '0, 32'h0000_0000, 1'b1, '{1'b0, 7'd101, 32'd4, 32'd6, 32'd406}},
    '{ROW_WRITE,  REG_CACHE_MODE,  32'h0000_0001, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0400, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0400, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0800, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0800, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0010, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0410, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0810, 1'b0, NO_WANT},
    '{ROW_WRITE,  REG_CACHE_MODE,  32'hFFFF_FFFE, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0410, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0410, 1'b0, NO_WANT},
    '{ROW_WRITE,  REG_OFFSET_BITS, 32'h0000_0002, 1'b0, NO_WANT},
    '{ROW_WRITE,  REG_INDEX_BITS,  32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0003, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'hFFFF_FFFC, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_WRITE,  REG_OFFSET_BITS, 32'h0000_000F, 1'b0, NO_WANT},
    '{ROW_WRITE,  REG_INDEX_BITS,  32'h0000_000F, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'hFFFF_FFFF, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'h7FFF_FFFF, 1'b0, NO_WANT},
    '{ROW_WRITE,  REG_NONE,        32'hFFFF_FFFF, 1'b0, NO_WANT},
    '{ROW_ACCESS, '0, 32'hFFFF_FFFF, 1'b0, NO_WANT}
  };

  // Random phases cover the range of each register and step past it: one
  // line with 4-byte blocks, the largest legal geometry, and offsets of 0
  // and 15 that the block must still take as written.
  localparam geometry_t PHASE_GEOMETRY [NUM_PHASES] = '{
    '{MODE_TWO_WAY, 4'd4,  4'd6},
    '{MODE_DIRECT,  4'd2,  4'd0},
    '{MODE_TWO_WAY, 4'd10, 4'd10},
    '{MODE_TWO_WAY, 4'd2,  4'd1},
    '{MODE_DIRECT,  4'd10, 4'd10},
    '{MODE_TWO_WAY, 4'd15, 4'd15},
    '{MODE_TWO_WAY, 4'd0,  4'd3},
    '{MODE_DIRECT,  4'd5,  4'd4}
  };

  // Idle profiles in percent per cycle: none, sender idle, receiver stalling,
  // and both at once.
  localparam int unsigned SENDER_IDLE    [4] = '{0, 66, 0, 17};
  localparam int unsigned RECEIVER_STALL [4] = '{0, 0, 66, 17};

  // Block ports. Every input has a known value from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [ADDR_W-1:0]     address_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  hit_o;
  logic [CYC_W-1:0]      access_cycles_o;
  logic [CNT_W-1:0]      miss_total_o;
  logic [CNT_W-1:0]      access_total_o;
  logic [CNT_W-1:0]      cycle_total_o;

  // The predictor's copy of the configuration, updated on each write beat.
  logic              cfg_mode        = MODE_DIRECT;
  logic [OFF_W-1:0]  cfg_offset_bits = OFFSET_BITS_RST;
  logic [IDXB_W-1:0] cfg_index_bits  = INDEX_BITS_RST;

  // The predictor's copy of the tag store and the running totals.
  logic              way0_valid [LINES];
  logic [ADDR_W-1:0] way0_tag   [LINES];
  logic              way1_valid [LINES];
  logic [ADDR_W-1:0] way1_tag   [LINES];
  logic              way1_newer [LINES];
  logic [CNT_W-1:0]  miss_count     = '0;
  logic [CNT_W-1:0]  access_count   = '0;
  logic [CNT_W-1:0]  charged_cycles = '0;

  // Results that accepted accesses still owe, oldest first.
  lookup_result_t expected_lookups [$];
  lookup_result_t head_result;
  lookup_result_t next_result;

  // A typed expectation for the access beat on offer, set by the sender.
  logic           typed_row  = 1'b0;
  lookup_result_t typed_want = '0;

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  int unsigned hold_requests   = 0;
  int unsigned results_seen    = 0;
  int unsigned error_count     = 0;

  cache_hit_miss_model_core #(
    .LINES      (LINES),
    .ADDR_WIDTH (ADDR_W)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .access_cycles_o (access_cycles_o),
    .miss_total_o    (miss_total_o),
    .access_total_o  (access_total_o),
    .cycle_total_o   (cycle_total_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Every mismatch lands here: one line is printed and the count goes up.
  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // Looks one address up in the predictor's tag store, updates the store and
  // the totals, and returns the result beat the block should produce.
  function automatic lookup_result_t lookup_cache(input logic [ADDR_W-1:0] addr);
    lookup_result_t    res;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] raw_line;
    int unsigned       line;
    int unsigned       tag_shift;
    tag_shift  = 32'(cfg_offset_bits) + 32'(cfg_index_bits);
    raw_line   = (addr >> cfg_offset_bits) & ((32'd1 << cfg_index_bits) - 32'd1);
    tag        = addr >> tag_shift;
    // Index fields wider than the store wrap around the line count.
    line       = raw_line % LINES;
    res        = '0;
    res.cycles = ONE_PROBE;
    if (way0_valid[line] && way0_tag[line] == tag) begin
      res.hit = 1'b1;
    end else if (cfg_mode == MODE_DIRECT || !way0_valid[line]) begin
      // Direct-mapped misses and an empty first way both fill the first way.
      way0_valid[line] = 1'b1;
      way0_tag[line]   = tag;
      way1_newer[line] = 1'b0;
    end else begin
      // The second way is only probed after the first one missed.
      res.cycles = TWO_PROBES;
      if (way1_valid[line] && way1_tag[line] == tag) begin
        res.hit = 1'b1;
      end else if (!way1_valid[line] || !way1_newer[line]) begin
        way1_valid[line] = 1'b1;
        way1_tag[line]   = tag;
        way1_newer[line] = 1'b1;
      end else begin
        way0_tag[line]   = tag;
        way1_newer[line] = 1'b0;
      end
    end
    if (!res.hit) begin
      res.cycles += MISS_PENALTY;
      miss_count++;
    end
    access_count++;
    charged_cycles += CNT_W'(res.cycles);
    res.misses    = miss_count;
    res.accesses  = access_count;
    res.cycle_sum = charged_cycles;
    return res;
  endfunction

  // Offers one access beat after a random idle gap. The task is entered and
  // left at a falling edge; valid stays high on return so that a following
  // beat can go out with no gap.
  task automatic drive_access(input logic [ADDR_W-1:0] addr, input logic typed,
                              input lookup_result_t want);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    typed_row  = typed;
    typed_want = want;
    in_valid_i <= 1'b1;
    address_i  <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stops offering accesses and waits until every result owed has come back.
  // The block then holds no access, which is when registers may be written.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes one register. Valid drops for a cycle afterwards so that a
  // following write raises it in a later time step.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // All beats are observed at the rising edge, before the block's own updates
  // of that edge land. Result beats are checked before a new access is
  // predicted, so the order within one edge is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("result beat with no access outstanding");
        end else begin
          head_result = expected_lookups.pop_front();
          check_field("hit", CNT_W'(hit_o), CNT_W'(head_result.hit));
          check_field("access_cycles", CNT_W'(access_cycles_o),
                      CNT_W'(head_result.cycles));
          check_field("miss_total", miss_total_o, head_result.misses);
          check_field("access_total", access_total_o, head_result.accesses);
          check_field("cycle_total", cycle_total_o, head_result.cycle_sum);
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_CACHE_MODE:  cfg_mode        = cfg_data_i[0];
          REG_OFFSET_BITS: cfg_offset_bits = cfg_data_i[OFF_W-1:0];
          REG_INDEX_BITS:  cfg_index_bits  = cfg_data_i[IDXB_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        // The predictor always advances; a typed row only replaces what is
        // compared for that beat.
        next_result = lookup_cache(address_i);
        expected_lookups.push_back(typed_row ? typed_want : next_result);
      end
    end
  end

  // The receiver decides its ready at each falling edge. A long hold, asked
  // for by the stimulus, is counted down here so that the sender keeps
  // offering beats while the block backs up.
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0]     tag_part;
    logic [ADDR_W-1:0]     line_part;
    logic [ADDR_W-1:0]     byte_part;
    logic [ADDR_W-1:0]     addr;
    logic [CFG_DATA_W-1:0] reg_data;
    geometry_t             geo;
    int unsigned           tag_shift;

    // Reset clears the valid bits and recent marks; the block's clearing pass
    // also zeroes the tags, never compared while the valid bit is clear.
    for (int i = 0; i < LINES; i++) begin
      way0_valid[i] = 1'b0;
      way0_tag[i]   = '0;
      way1_valid[i] = 1'b0;
      way1_tag[i]   = '0;
      way1_newer[i] = 1'b0;
    end

    // Reset is held from time zero and released at a falling edge. The block
    // then runs its clearing pass with in_ready_o low, which the first access
    // simply waits out.
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Register writes only go out once the block is idle.
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        wait_for_drain();
        write_register(directed_rows[r].reg_index, directed_rows[r].value);
      end else begin
        drive_access(directed_rows[r].value, directed_rows[r].typed,
                     directed_rows[r].want);
      end
    end

    // Random phases, each with its own geometry and idle profile.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_drain();
      geo             = PHASE_GEOMETRY[p];
      sender_idle_pct = SENDER_IDLE[p % 4];
      stall_pct       = RECEIVER_STALL[p % 4];

      // Upper data bits are random; the block must ignore them.
      reg_data    = $urandom;
      reg_data[0] = geo.mode;
      write_register(REG_CACHE_MODE, reg_data);
      reg_data               = $urandom;
      reg_data[OFF_W-1:0]    = geo.offset_bits;
      write_register(REG_OFFSET_BITS, reg_data);
      reg_data               = $urandom;
      reg_data[IDXB_W-1:0]   = geo.index_bits;
      write_register(REG_INDEX_BITS, reg_data);
      if ($urandom_range(1) == 1) write_register(REG_NONE, $urandom);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // In the pressure phase the receiver holds off for a long stretch
        // while accesses keep coming, and later the sender pauses until
        // every result has come back.
        if (p == PRESSURE_PHASE && n == 10) hold_requests++;
        if (p == PRESSURE_PHASE && n == 50) wait_for_drain();

        if ($urandom_range(99) < 20) begin
          // Noise: any address at all.
          addr = $urandom;
        end else begin
          // A small working set of tags over a few lines, so that hits,
          // conflicts and replacements in both ways are frequent. Now and
          // then the tag is inverted to reach the top address bits.
          tag_shift = 32'(cfg_offset_bits) + 32'(cfg_index_bits);
          tag_part  = $urandom_range(5);
          if ($urandom_range(9) == 0) tag_part = ~tag_part;
          line_part = $urandom_range(7);
          byte_part = $urandom & ((32'd1 << cfg_offset_bits) - 32'd1);
          addr = (tag_part << tag_shift) | (line_part << cfg_offset_bits) | byte_part;
        end
        drive_access(addr, 1'b0, NO_WANT);
      end
    end

    wait_for_drain();
    // Run on so that a stray extra result beat would be seen.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/chm_pkg.sv
rtl/chm_index_unit.sv
rtl/chm_line_ram.sv
rtl/cache_hit_miss_model_core.sv
sim/tb_cache_hit_miss_model_core.sv
